>>> hdl/fsr_pkg.sv
// ----------------------------------------------------------------------------
// fsr_pkg
// Operation and status codes, walk modes and the control and status bundles
// shared by the controller and the datapath of the queue.
// ----------------------------------------------------------------------------
package fsr_pkg;

	localparam logic [1:0] OP_ENQ     = 2'd0;
	localparam logic [1:0] OP_DEQ     = 2'd1;
	localparam logic [1:0] OP_DEL_VAL = 2'd2;
	localparam logic [1:0] OP_DEL_POS = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	localparam int DATA_W  = 32;
	localparam int POS_W   = 8;
	localparam int OUT_CNT_W = 5;

	typedef enum logic [1:0] {
		MODE_SCAN,
		MODE_BY_VALUE,
		MODE_BY_POS
	} walk_mode_t;

	typedef struct packed {
		logic load;
		logic mutate;
		logic walk;
		logic commit;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic walk_done;
	} dp_status_t;

endpackage

>>> hdl/fsr_ram.sv
// ----------------------------------------------------------------------------
// fsr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fsr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hdl/fsr_ctrl.sv
// ----------------------------------------------------------------------------
// fsr_ctrl
// Sequencer for one request: capture, update, walk of the store, commit and
// hand-off to the output register.
// ----------------------------------------------------------------------------
module fsr_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	output fsr_pkg::ctrl_cmd_t     cmd,
	input  fsr_pkg::dp_status_t    dp_status
);

	import fsr_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUT  = 3'd1;
	localparam logic [2:0] S_WALK = 3'd2;
	localparam logic [2:0] S_DONE = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_free;
	logic       out_valid_q;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_MUT;
				end
			end
			S_MUT: begin
				cmd.mutate = 1'b1;
				state_d    = S_WALK;
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (dp_status.walk_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				cmd.commit = 1'b1;
				state_d    = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> hdl/fsr_datapath.sv
// ----------------------------------------------------------------------------
// fsr_datapath
// Queue pointers, the entry store, the compaction walk and the result
// register.
// ----------------------------------------------------------------------------
module fsr_datapath #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fsr_pkg::ctrl_cmd_t           cmd,
	output fsr_pkg::dp_status_t          dp_status,
	input  logic [1:0]                   in_op,
	input  logic [fsr_pkg::DATA_W-1:0]   in_value,
	input  logic [fsr_pkg::POS_W-1:0]    in_position,
	output logic [1:0]                   out_status,
	output logic [fsr_pkg::DATA_W-1:0]   out_head,
	output logic [fsr_pkg::DATA_W-1:0]   out_tail,
	output logic [fsr_pkg::OUT_CNT_W-1:0] out_count,
	output logic [fsr_pkg::DATA_W-1:0]   out_largest,
	output logic                         out_empty
);

	import fsr_pkg::*;

	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = CW + 1;
	localparam int PW = (CW > POS_W) ? CW : POS_W;
	localparam int XW = (CW > OUT_CNT_W) ? CW : OUT_CNT_W;

	logic [1:0]        op_q;
	logic [DATA_W-1:0] val_q;
	logic [1:0]        st_q;
	walk_mode_t        mode_q;
	logic [IW-1:0]     head_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     rd_idx_q;
	logic [CW-1:0]     rd_off_s1;
	logic              rd_vld_s1;
	logic [CW-1:0]     kept_q;
	logic [PW-1:0]     pos_q;
	logic [DATA_W-1:0] hv_q;
	logic [DATA_W-1:0] tv_q;
	logic [DATA_W-1:0] mx_q;

	logic              ram_we;
	logic [IW-1:0]     ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic              ram_re;
	logic [DATA_W-1:0] ram_rdata;
	logic              drop;
	logic              keep_item;
	logic              full;
	logic              pos_bad;
	logic [PW-1:0]     in_pos_ext;

	function automatic logic [IW-1:0] slot(input logic [IW-1:0] h, input logic [CW-1:0] off);
		logic [SW-1:0] sum;
		sum = SW'(h) + SW'(off);
		if (sum >= SW'(QUEUE_DEPTH)) begin
			sum = sum - SW'(QUEUE_DEPTH);
		end
		return sum[IW-1:0];
	endfunction

	assign full       = (count_q == CW'(QUEUE_DEPTH));
	assign in_pos_ext = PW'(in_position);
	assign pos_bad    = (in_pos_ext == '0) || (in_pos_ext > PW'(count_q));

	assign ram_re = cmd.walk && (rd_idx_q != count_q);

	always_comb begin
		unique case (mode_q)
			MODE_BY_VALUE: drop = (ram_rdata == val_q);
			MODE_BY_POS:   drop = ((PW'(rd_off_s1) + PW'(1)) == pos_q);
			default:       drop = 1'b0;
		endcase
	end

	assign keep_item = rd_vld_s1 && !drop;

	// The compaction write always lands at or behind the read in flight.
	always_comb begin
		if (cmd.mutate) begin
			ram_we    = (op_q == OP_ENQ) && (st_q == ST_OK);
			ram_waddr = slot(head_q, count_q);
			ram_wdata = val_q;
		end else begin
			ram_we    = keep_item && (mode_q != MODE_SCAN);
			ram_waddr = slot(head_q, kept_q);
			ram_wdata = ram_rdata;
		end
	end

	fsr_ram #(
		.WIDTH (DATA_W),
		.DEPTH (QUEUE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (slot(head_q, rd_idx_q)),
		.rdata (ram_rdata)
	);

	assign dp_status.walk_done = (rd_idx_q == count_q) && !rd_vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			count_q   <= '0;
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
			kept_q    <= '0;
			st_q      <= ST_OK;
			mode_q    <= MODE_SCAN;
			op_q      <= OP_ENQ;
		end else begin
			if (cmd.load) begin
				op_q   <= in_op;
				mode_q <= MODE_SCAN;
				priority if (in_op == OP_ENQ) begin
					st_q <= full ? ST_FULL : ST_OK;
				end else if (count_q == '0) begin
					st_q <= ST_EMPTY;
				end else if (in_op == OP_DEQ) begin
					st_q <= ST_OK;
				end else if (in_op == OP_DEL_VAL) begin
					st_q   <= ST_OK;
					mode_q <= MODE_BY_VALUE;
				end else if (pos_bad) begin
					st_q <= ST_NOTFOUND;
				end else begin
					st_q   <= ST_OK;
					mode_q <= MODE_BY_POS;
				end
			end
			if (cmd.mutate) begin
				rd_idx_q <= '0;
				kept_q   <= '0;
				if (st_q == ST_OK) begin
					if (op_q == OP_ENQ) begin
						count_q <= count_q + CW'(1);
					end else if (op_q == OP_DEQ) begin
						count_q <= count_q - CW'(1);
						head_q  <= (count_q == CW'(1)) ? '0 : slot(head_q, CW'(1));
					end
				end
			end
			rd_vld_s1 <= ram_re;
			if (ram_re) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end
			if (keep_item) begin
				kept_q <= kept_q + CW'(1);
			end
			if (cmd.commit && (mode_q != MODE_SCAN)) begin
				count_q <= kept_q;
				if (kept_q == '0) begin
					head_q <= '0;
				end
				if ((mode_q == MODE_BY_VALUE) && (kept_q == count_q)) begin
					st_q <= ST_NOTFOUND;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q <= in_value;
			pos_q <= in_pos_ext;
		end
		if (ram_re) begin
			rd_off_s1 <= rd_idx_q;
		end
		if (keep_item) begin
			tv_q <= ram_rdata;
			if (kept_q == '0) begin
				hv_q <= ram_rdata;
				mx_q <= ram_rdata;
			end else if ($signed(ram_rdata) > $signed(mx_q)) begin
				mx_q <= ram_rdata;
			end
		end
		if (cmd.out_load) begin
			out_status  <= st_q;
			out_count   <= OUT_CNT_W'(XW'(kept_q));
			out_empty   <= (kept_q == '0);
			out_head    <= (kept_q == '0) ? '0 : hv_q;
			out_tail    <= (kept_q == '0) ? '0 : tv_q;
			out_largest <= (kept_q == '0) ? '0 : mx_q;
		end
	end

endmodule

>>> hdl/fifo_with_selective_removal.sv
// ----------------------------------------------------------------------------
// fifo_with_selective_removal
// Bounded FIFO of signed words with enqueue, dequeue, remove-by-value and
// remove-by-position requests, one status and snapshot result per request.
// ----------------------------------------------------------------------------
// Each request walks the entry store before its result is offered. The
// entries walked are those held at acceptance, one more after an enqueue
// that is taken, one fewer after a dequeue that is taken. The walk goes
// through the single-read-port entry store, one entry per cycle, and
// compacts the queue and gathers the head, tail and largest value. A new
// request is taken once the previous result has been placed in the output
// register; the output register may still be waiting to be taken.
module fifo_with_selective_removal #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [39:0]  s_axis_tdata,   // data_value[31:0], position[39:32]
	input  logic [1:0]   s_axis_tuser,   // op[1:0]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// head_value[31:0], tail_value[63:32], entry_count[68:64],
	// largest_value[100:69], is_empty[101], zero[103:102]
	output logic [103:0] m_axis_tdata,
	output logic [1:0]   m_axis_tuser    // status[1:0]
);

	import fsr_pkg::*;

	ctrl_cmd_t         cmd;
	dp_status_t        dp_status;
	logic [DATA_W-1:0] head_value;
	logic [DATA_W-1:0] tail_value;
	logic [DATA_W-1:0] largest_value;
	logic [OUT_CNT_W-1:0] entry_count;
	logic              is_empty;

	fsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.dp_status (dp_status)
	);

	fsr_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.dp_status   (dp_status),
		.in_op       (s_axis_tuser),
		.in_value    (s_axis_tdata[31:0]),
		.in_position (s_axis_tdata[39:32]),
		.out_status  (m_axis_tuser),
		.out_head    (head_value),
		.out_tail    (tail_value),
		.out_count   (entry_count),
		.out_largest (largest_value),
		.out_empty   (is_empty)
	);

	assign m_axis_tdata = {2'b00, is_empty, largest_value, entry_count, tail_value, head_value};

endmodule

>>> sim/fifo_removal_checker.sv
// ----------------------------------------------------------------------------
// fifo_removal_checker
// Watches both stream channels of the queue. It keeps its own model of the
// queue, works out the status and snapshot that each accepted request must
// produce, and compares every accepted result field by field in order.
// ----------------------------------------------------------------------------
module fifo_removal_checker #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [39:0]  s_tdata,   // data_value[31:0], position[39:32]
	input  logic [1:0]   s_tuser,   // op[1:0]
	input  logic         m_tvalid,
	input  logic         m_tready,
	// head_value[31:0], tail_value[63:32], entry_count[68:64],
	// largest_value[100:69], is_empty[101], zero[103:102]
	input  logic [103:0] m_tdata,
	input  logic [1:0]   m_tuser,   // status[1:0]
	output int           fail_count,
	output int           pending_results
);

	import fsr_pkg::*;

	typedef struct packed {
		logic [1:0]        status;
		logic signed [31:0] head_value;
		logic signed [31:0] tail_value;
		logic [4:0]        entry_count;
		logic signed [31:0] largest_value;
		logic              is_empty;
	} snapshot_t;

	logic signed [31:0] queue_words [QUEUE_DEPTH];
	int                 front_idx;
	int                 word_count;
	snapshot_t          expected_snapshots [$];
	snapshot_t          want;

	initial begin
		fail_count = 0;
		pending_results = 0;
	end

	function automatic int slot(input int offset);
		return (front_idx + offset) % QUEUE_DEPTH;
	endfunction

	// Applies one request to the model queue and returns the snapshot after it.
	function automatic snapshot_t apply_request(input logic [1:0] op,
			input logic signed [31:0] value, input logic [7:0] pos);
		snapshot_t         snap;
		int                kept;
		int                n;
		logic signed [31:0] w;
		logic              drop;
		snap = '0;
		snap.status = ST_OK;
		if (op == OP_ENQ) begin
			if (word_count >= QUEUE_DEPTH) begin
				snap.status = ST_FULL;
			end else begin
				queue_words[slot(word_count)] = value;
				word_count++;
			end
		end else if (word_count == 0) begin
			snap.status = ST_EMPTY;
		end else if (op == OP_DEQ) begin
			front_idx = slot(1);
			word_count--;
		end else if (op == OP_DEL_POS && (pos == 0 || int'(pos) > word_count)) begin
			snap.status = ST_NOTFOUND;
		end else begin
			// Compact in place so that the surviving entries keep their order.
			kept = 0;
			n = word_count;
			for (int i = 0; i < n; i++) begin
				w = queue_words[slot(i)];
				drop = (op == OP_DEL_VAL) ? (w == value) : (i + 1 == int'(pos));
				if (!drop) begin
					queue_words[slot(kept)] = w;
					kept++;
				end
			end
			word_count = kept;
			if (kept == n) snap.status = ST_NOTFOUND;
		end
		if (word_count == 0) front_idx = 0;
		if (word_count > 0) begin
			snap.head_value = queue_words[slot(0)];
			snap.tail_value = queue_words[slot(word_count - 1)];
			snap.largest_value = snap.head_value;
			for (int i = 1; i < word_count; i++) begin
				if (queue_words[slot(i)] > snap.largest_value)
					snap.largest_value = queue_words[slot(i)];
			end
		end
		snap.entry_count = word_count[4:0];
		snap.is_empty = (word_count == 0);
		return snap;
	endfunction

	task automatic check_field(input string field, input logic signed [31:0] exp_val,
			input logic signed [31:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected %0d, actual %0d", field, exp_val, act_val);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_idx = 0;
			word_count = 0;
			expected_snapshots.delete();
		end else begin
			if (s_tvalid && s_tready)
				expected_snapshots.push_back(apply_request(s_tuser, s_tdata[31:0],
					s_tdata[39:32]));
			if (m_tvalid && m_tready) begin
				if (expected_snapshots.size() == 0) begin
					$error("result offered with no request outstanding");
					fail_count++;
				end else begin
					want = expected_snapshots.pop_front();
					check_field("status", {30'd0, want.status}, {30'd0, m_tuser});
					check_field("head_value", want.head_value, m_tdata[31:0]);
					check_field("tail_value", want.tail_value, m_tdata[63:32]);
					check_field("entry_count", {27'd0, want.entry_count},
						{27'd0, m_tdata[68:64]});
					check_field("largest_value", want.largest_value, m_tdata[100:69]);
					check_field("is_empty", {31'd0, want.is_empty}, {31'd0, m_tdata[101]});
				end
			end
		end
		pending_results = expected_snapshots.size();
	end

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the queue with a directed set of requests followed by random ones
// under three idling mixes, a long output stall and drain pauses, and reports
// the verdict from the failure and pending-result counts of the checker.
// ----------------------------------------------------------------------------
module tb_top;
	import fsr_pkg::*;

	localparam int QUEUE_DEPTH = 16;
	localparam int PHASE_ITEMS = 500;
	localparam int CYCLE_LIMIT = 400000;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [39:0]  s_axis_tdata;
	logic [1:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [103:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;

	int fail_count;
	int pending_results;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_len;
	int hold_left;
	int cycle_count;
	int enq_weight;

	fifo_with_selective_removal #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	fifo_removal_checker #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_axis_tvalid),
		.s_tready(s_axis_tready),
		.s_tdata(s_axis_tdata),
		.s_tuser(s_axis_tuser),
		.m_tvalid(m_axis_tvalid),
		.m_tready(m_axis_tready),
		.m_tdata(m_axis_tdata),
		.m_tuser(m_axis_tuser),
		.fail_count(fail_count),
		.pending_results(pending_results)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Receiver side: random back-pressure, with a long hold-off when one is requested.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_len > 0) begin
				hold_left = hold_len;
				hold_len = 0;
				while (hold_left > 0) begin
					m_axis_tready <= 1'b0;
					hold_left--;
					@(negedge clk);
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_request(input logic [1:0] op, input logic [31:0] value,
			input logic [7:0] pos);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {pos, value};
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain;
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_results != 0) @(negedge clk);
	endtask

	task automatic random_request(input int idx);
		logic [1:0]  op;
		logic [31:0] value;
		logic [7:0]  pos;
		int          r;
		// Swing between filling and emptying so that every fill level is visited.
		if (idx % 64 == 0) enq_weight = (enq_weight > 50) ? 35 : 65;
		r = $urandom_range(99);
		if (r < enq_weight) op = OP_ENQ;
		else if (r < enq_weight + (100 - enq_weight) * 4 / 10) op = OP_DEQ;
		else if (r < enq_weight + (100 - enq_weight) * 7 / 10) op = OP_DEL_VAL;
		else op = OP_DEL_POS;
		// A small pool of values makes duplicates, and so multi-entry removals, common.
		case ($urandom_range(9))
			0: value = 32'h0000_0000;
			1: value = 32'hFFFF_FFFF;
			2: value = 32'h7FFF_FFFF;
			3: value = 32'h8000_0000;
			4: value = 32'd42;
			5: value = -32'sd100;
			6: value = 32'd7;
			default: value = $urandom;
		endcase
		if ($urandom_range(9) == 0) pos = 8'($urandom_range(255));
		else pos = 8'($urandom_range(QUEUE_DEPTH + 1, 0));
		send_request(op, value, pos);
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_ENQ;
		send_idle_pct = 37;
		recv_idle_pct = 77;
		hold_len = 0;
		cycle_count = 0;
		enq_weight = 35;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Operations on an empty queue.
		send_request(OP_DEQ, 32'd0, 8'd1);
		send_request(OP_DEL_VAL, 32'd0, 8'd0);
		send_request(OP_DEL_POS, 32'd0, 8'd1);
		// Fill with the extremes, -1 and duplicates, then try one more.
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			case (i % 5)
				0: send_request(OP_ENQ, 32'h7FFF_FFFF, 8'd0);
				1: send_request(OP_ENQ, 32'h8000_0000, 8'd0);
				2: send_request(OP_ENQ, 32'hFFFF_FFFF, 8'd0);
				3: send_request(OP_ENQ, 32'd0, 8'd0);
				default: send_request(OP_ENQ, i, 8'd0);
			endcase
		end
		send_request(OP_ENQ, 32'd5, 8'hFF);
		send_request(OP_DEL_POS, 32'd0, 8'd16);
		send_request(OP_DEL_POS, 32'd0, 8'd1);
		send_request(OP_DEL_POS, 32'd0, 8'd0);
		send_request(OP_DEL_POS, 32'hFFFF_FFFF, 8'd255);
		send_request(OP_DEL_VAL, 32'hFFFF_FFFF, 8'd0);
		send_request(OP_DEL_VAL, 32'h1234_5678, 8'd0);
		send_request(OP_DEQ, 32'd0, 8'd0);
		drain();

		for (int i = 0; i < PHASE_ITEMS; i++) random_request(i);
		drain();

		send_idle_pct = 77;
		recv_idle_pct = 37;
		for (int i = 0; i < PHASE_ITEMS; i++) random_request(i);
		drain();

		// No idling; open with a long output stall so the input backs up.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_len = 300;
		for (int i = 0; i < PHASE_ITEMS; i++) random_request(i);
		drain();

		repeat (QUEUE_DEPTH + 10) @(negedge clk);
		if (fail_count == 0 && pending_results == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
